### rtl/trs_pkg.sv
// Shared types and constants for the TFTP receive sequencer.
// No dependencies; used by every module of the block.
package trs_pkg;

  // Data block size and the datagram length that marks a full block
  localparam int unsigned BLOCK_SIZE     = 512;
  localparam logic [9:0]  FULL_DGRAM_LEN = 10'(BLOCK_SIZE + 4);
  localparam logic [9:0]  HDR_LEN        = 10'd4;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Protocol constants
  localparam logic [15:0] TFTP_PORT    = 16'd69;
  localparam logic [7:0]  OPC_DATA     = 8'd3;
  localparam logic [7:0]  OPC_MAXLEGAL = 8'd5;
  localparam logic [2:0]  ERR_ILLEGAL  = 3'd4;
  localparam logic [2:0]  ERR_TID      = 3'd5;

  // Reset values of configuration registers
  localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd5;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  typedef enum logic [1:0] {
    CFG_SERVER_ADDR   = 2'd0,
    CFG_FLASH_BASE    = 2'd1,
    CFG_RETRY_LIMIT   = 2'd2,
    CFG_TIMEOUT_TICKS = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DGRAM  = 2'd1,
    OP_TICK   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RRQ  = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RUN  = 4'b0010,
    PH_DONE = 4'b0100,
    PH_FAIL = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [31:0] server_address;
    logic [31:0] flash_base;
    logic [7:0]  retry_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Classified item as queued between front and back
  typedef struct packed {
    op_t         op;
    logic        addr_ok;
    logic [15:0] src_port;
    logic        is_data;
    logic        is_illegal;
    logic [15:0] block_number;
    logic [9:0]  wr_len;
    logic        last_block;
  } item_t;

endpackage

### rtl/trs_front.sv
// Front end: accepts input items and classifies them.
// Depends on trs_pkg; feeds trs_queue.
module trs_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_src_address,
  input  logic [15:0]        in_src_port,
  input  logic [7:0]         in_pkt_opcode,
  input  logic [15:0]        in_block_number,
  input  logic [9:0]         in_dgram_length,
  input  logic [31:0]        server_address,
  input  logic               q_full,
  output logic               push,
  output trs_pkg::item_t     push_item
);

  // Take an item whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Classification that needs no sequencer state
  always_comb begin
    push_item.op           = trs_pkg::op_t'(in_op);
    push_item.addr_ok      = (in_src_address == server_address);
    push_item.src_port     = in_src_port;
    push_item.is_data      = (in_pkt_opcode == trs_pkg::OPC_DATA);
    push_item.is_illegal   = (in_pkt_opcode > trs_pkg::OPC_MAXLEGAL);
    push_item.block_number = in_block_number;
    // Payload length, zero for runt datagrams
    push_item.wr_len       = (in_dgram_length >= trs_pkg::HDR_LEN) ?
                             (in_dgram_length - trs_pkg::HDR_LEN) : 10'd0;
    push_item.last_block   = (in_dgram_length != trs_pkg::FULL_DGRAM_LEN);
  end

endmodule

### rtl/trs_queue.sv
// Small FIFO of classified items between front and back.
// Depends on trs_pkg.
module trs_queue #(
  parameter int unsigned DEPTH = trs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  trs_pkg::item_t     push_item,
  input  logic               pop,
  output logic               pop_valid,
  output trs_pkg::item_t     pop_item,
  output logic               full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  trs_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign pop_valid = (count_r != '0);
  assign full      = (count_r == DEPTH_CNT);
  assign pop_item  = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/trs_back.sv
// Back end: transfer state machine and registered result.
// Depends on trs_pkg; drains trs_queue.
module trs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  trs_pkg::cfg_t      cfg,
  input  logic               pop_valid,
  input  trs_pkg::item_t     pop_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_send_kind,
  output logic [15:0]        out_send_block,
  output logic [2:0]         out_error_code,
  output logic [15:0]        out_dest_port,
  output logic               out_write_enable,
  output logic [31:0]        out_write_address,
  output logic [9:0]         out_write_length,
  output logic [1:0]         out_status
);

  // Transfer state
  trs_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     block_count_r, block_count_nxt;
  logic [31:0]     bytes_r, bytes_nxt;
  logic [15:0]     server_port_r, server_port_nxt;
  logic            latched_r, latched_nxt;
  logic [7:0]      retry_r, retry_nxt;
  logic [15:0]     tick_r, tick_nxt;
  trs_pkg::kind_t  last_kind_r, last_kind_nxt;
  logic [15:0]     last_value_r, last_value_nxt;

  // Result register
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [15:0]     send_block_r, send_block_nxt;
  logic [2:0]      error_code_r, error_code_nxt;
  logic [15:0]     dest_port_r, dest_port_nxt;
  logic            wr_en_r, wr_en_nxt;
  logic [31:0]     wr_addr_r, wr_addr_nxt;
  logic [9:0]      wr_len_r, wr_len_nxt;
  logic [1:0]      status_r, status_nxt;

  logic            take;
  logic            do_emit;
  logic            use_retry;
  trs_pkg::kind_t  em_kind;
  logic [15:0]     em_value;
  logic [15:0]     cur_port;
  logic [15:0]     dest;
  logic [7:0]      retry_inc;
  logic            in_seq;

  // Move an item on when the result slot is free or being emptied
  assign take = pop_valid && (!out_valid_r || out_ready);
  assign pop  = take;

  always_comb begin
    phase_nxt       = phase_r;
    block_count_nxt = block_count_r;
    bytes_nxt       = bytes_r;
    server_port_nxt = server_port_r;
    latched_nxt     = latched_r;
    retry_nxt       = retry_r;
    tick_nxt        = tick_r;
    last_kind_nxt   = last_kind_r;
    last_value_nxt  = last_value_r;
    do_emit         = 1'b0;
    use_retry       = 1'b0;
    em_kind         = trs_pkg::KIND_NONE;
    em_value        = 16'd0;
    wr_en_nxt       = 1'b0;
    wr_addr_nxt     = 32'd0;
    wr_len_nxt      = 10'd0;
    cur_port        = latched_r ? server_port_r : pop_item.src_port;
    in_seq          = ({1'b0, block_count_r} + 17'd1) == {1'b0, pop_item.block_number};
    retry_inc       = retry_r + 8'd1;

    case (pop_item.op)
      trs_pkg::OP_START: begin
        phase_nxt       = trs_pkg::PH_RUN;
        block_count_nxt = 16'd0;
        bytes_nxt       = 32'd0;
        server_port_nxt = 16'd0;
        latched_nxt     = 1'b0;
        retry_nxt       = 8'd0;
        tick_nxt        = 16'd0;
        do_emit         = 1'b1;
        em_kind         = trs_pkg::KIND_RRQ;
      end
      trs_pkg::OP_TICK: begin
        if (phase_r == trs_pkg::PH_RUN) begin
          // Timeout resends the last packet
          if (tick_r >= cfg.timeout_ticks) begin
            tick_nxt  = 16'd0;
            do_emit   = 1'b1;
            em_kind   = last_kind_r;
            em_value  = last_value_r;
            use_retry = 1'b1;
          end else begin
            tick_nxt = tick_r + 16'd1;
          end
        end
      end
      trs_pkg::OP_DGRAM: begin
        if (phase_r == trs_pkg::PH_RUN) begin
          tick_nxt = 16'd0;
          if (pop_item.addr_ok) begin
            // First datagram from the server fixes its port
            if (!latched_r) begin
              server_port_nxt = pop_item.src_port;
              latched_nxt     = 1'b1;
            end
            if (pop_item.src_port != cur_port) begin
              do_emit  = 1'b1;
              em_kind  = trs_pkg::KIND_ERR;
              em_value = {13'd0, trs_pkg::ERR_TID};
            end else if (!pop_item.is_data) begin
              if (pop_item.is_illegal) begin
                do_emit  = 1'b1;
                em_kind  = trs_pkg::KIND_ERR;
                em_value = {13'd0, trs_pkg::ERR_ILLEGAL};
              end
              use_retry = 1'b1;
            end else begin
              // Next block in sequence goes to flash
              if (in_seq) begin
                wr_en_nxt       = 1'b1;
                wr_addr_nxt     = cfg.flash_base + bytes_r;
                wr_len_nxt      = pop_item.wr_len;
                bytes_nxt       = bytes_r + {22'd0, pop_item.wr_len};
                block_count_nxt = pop_item.block_number;
              end
              do_emit   = 1'b1;
              em_kind   = trs_pkg::KIND_ACK;
              em_value  = in_seq ? pop_item.block_number : block_count_r;
              retry_nxt = 8'd0;
              if (pop_item.last_block) begin
                phase_nxt = trs_pkg::PH_DONE;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (use_retry) begin
      retry_nxt = retry_inc;
      if (retry_inc >= cfg.retry_limit) begin
        phase_nxt = trs_pkg::PH_FAIL;
      end
    end

    if (do_emit) begin
      last_kind_nxt  = em_kind;
      last_value_nxt = em_value;
    end

    // Packet fields
    dest           = latched_nxt ? server_port_nxt : trs_pkg::TFTP_PORT;
    kind_nxt       = em_kind;
    send_block_nxt = (em_kind == trs_pkg::KIND_ACK) ? em_value : 16'd0;
    error_code_nxt = (em_kind == trs_pkg::KIND_ERR) ? em_value[2:0] : 3'd0;
    dest_port_nxt  = (em_kind == trs_pkg::KIND_NONE) ? 16'd0 : dest;

    case (phase_nxt)
      trs_pkg::PH_IDLE: status_nxt = trs_pkg::ST_IDLE;
      trs_pkg::PH_RUN:  status_nxt = trs_pkg::ST_RUN;
      trs_pkg::PH_DONE: status_nxt = trs_pkg::ST_DONE;
      trs_pkg::PH_FAIL: status_nxt = trs_pkg::ST_FAIL;
      default:          status_nxt = trs_pkg::ST_IDLE;
    endcase

    // Result slot occupancy
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= trs_pkg::PH_IDLE;
      block_count_r <= 16'd0;
      bytes_r       <= 32'd0;
      server_port_r <= 16'd0;
      latched_r     <= 1'b0;
      retry_r       <= 8'd0;
      tick_r        <= 16'd0;
      last_kind_r   <= trs_pkg::KIND_NONE;
      last_value_r  <= 16'd0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r       <= phase_nxt;
        block_count_r <= block_count_nxt;
        bytes_r       <= bytes_nxt;
        server_port_r <= server_port_nxt;
        latched_r     <= latched_nxt;
        retry_r       <= retry_nxt;
        tick_r        <= tick_nxt;
        last_kind_r   <= last_kind_nxt;
        last_value_r  <= last_value_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r       <= kind_nxt;
      send_block_r <= send_block_nxt;
      error_code_r <= error_code_nxt;
      dest_port_r  <= dest_port_nxt;
      wr_en_r      <= wr_en_nxt;
      wr_addr_r    <= wr_addr_nxt;
      wr_len_r     <= wr_len_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_send_kind     = kind_r;
  assign out_send_block    = send_block_r;
  assign out_error_code    = error_code_r;
  assign out_dest_port     = dest_port_r;
  assign out_write_enable  = wr_en_r;
  assign out_write_address = wr_addr_r;
  assign out_write_length  = wr_len_r;
  assign out_status        = status_r;

endmodule

### rtl/tftp_receive_sequencer_core.sv
// An accepted item goes through a queue entry, then the result register, before it is valid.
// One item per cycle while the result side drains; the back-end state updates once per item.
// The front queue keeps taking items while a result waits, until its entries are full.
// Reset: synchronous, active low; clears transfer state, queue and result valid,
// and loads the configuration registers with their defaults.
// Top level of the TFTP receive sequencer; uses trs_pkg, trs_front, trs_queue, trs_back.
module tftp_receive_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = trs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_src_address,
  input  logic [15:0] in_src_port,
  input  logic [7:0]  in_pkt_opcode,
  input  logic [15:0] in_block_number,
  input  logic [9:0]  in_dgram_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_send_kind,
  output logic [15:0] out_send_block,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_dest_port,
  output logic        out_write_enable,
  output logic [31:0] out_write_address,
  output logic [9:0]  out_write_length,
  output logic [1:0]  out_status
);

  trs_pkg::cfg_t  cfg_r;
  trs_pkg::item_t push_item;
  trs_pkg::item_t pop_item;
  logic           push;
  logic           pop;
  logic           pop_valid;
  logic           q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.server_address <= 32'd0;
      cfg_r.flash_base     <= 32'd0;
      cfg_r.retry_limit    <= trs_pkg::RETRY_LIMIT_RST;
      cfg_r.timeout_ticks  <= trs_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (trs_pkg::cfg_idx_t'(cfg_index))
        trs_pkg::CFG_SERVER_ADDR:   cfg_r.server_address <= cfg_data;
        trs_pkg::CFG_FLASH_BASE:    cfg_r.flash_base     <= cfg_data;
        trs_pkg::CFG_RETRY_LIMIT:   cfg_r.retry_limit    <= cfg_data[7:0];
        trs_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  trs_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_src_address  (in_src_address),
    .in_src_port     (in_src_port),
    .in_pkt_opcode   (in_pkt_opcode),
    .in_block_number (in_block_number),
    .in_dgram_length (in_dgram_length),
    .server_address  (cfg_r.server_address),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  trs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .full      (q_full)
  );

  trs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .pop_valid         (pop_valid),
    .pop_item          (pop_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_send_kind     (out_send_kind),
    .out_send_block    (out_send_block),
    .out_error_code    (out_error_code),
    .out_dest_port     (out_dest_port),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_write_length  (out_write_length),
    .out_status        (out_status)
  );

endmodule

### rtl/trs_checker.sv
// Port-level checks for the TFTP receive sequencer, bound to the top level.
// Depends on trs_pkg and tftp_receive_sequencer_core.
module trs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_send_kind,
  input logic [15:0] out_send_block,
  input logic [2:0]  out_error_code,
  input logic [15:0] out_dest_port,
  input logic        out_write_enable,
  input logic [31:0] out_write_address,
  input logic [9:0]  out_write_length
);

  // No result right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_kind) &&
    $stable(out_send_block) && $stable(out_write_address))
    else $error("stalled result changed");

  // No packet means empty packet fields
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_kind == trs_pkg::KIND_NONE |->
    out_send_block == 16'd0 && out_error_code == 3'd0 && out_dest_port == 16'd0)
    else $error("packet fields set without a packet");

  // Error packets only carry the two codes the sequencer produces
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_kind == trs_pkg::KIND_ERR |->
    out_error_code == trs_pkg::ERR_ILLEGAL || out_error_code == trs_pkg::ERR_TID)
    else $error("unexpected error code");

  // No flash write means empty write fields
  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |->
    out_write_address == 32'd0 && out_write_length == 10'd0)
    else $error("write fields set without a write");

endmodule

bind tftp_receive_sequencer_core trs_checker u_trs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_send_kind     (out_send_kind),
  .out_send_block    (out_send_block),
  .out_error_code    (out_error_code),
  .out_dest_port     (out_dest_port),
  .out_write_enable  (out_write_enable),
  .out_write_address (out_write_address),
  .out_write_length  (out_write_length)
);

### bench/tftp_reply_checker.sv
// Checker for the TFTP receive sequencer: mirrors the configuration writes, predicts one reply
// per accepted item and compares it field by field with each accepted result.
// Depends on trs_pkg for the op, kind, status and register codes.
module tftp_reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_src_address,
  input  logic [15:0] in_src_port,
  input  logic [7:0]  in_pkt_opcode,
  input  logic [15:0] in_block_number,
  input  logic [9:0]  in_dgram_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_send_kind,
  input  logic [15:0] out_send_block,
  input  logic [2:0]  out_error_code,
  input  logic [15:0] out_dest_port,
  input  logic        out_write_enable,
  input  logic [31:0] out_write_address,
  input  logic [9:0]  out_write_length,
  input  logic [1:0]  out_status,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    trs_pkg::kind_t   kind;
    logic [15:0]      ack_block;
    logic [2:0]       fault_code;
    logic [15:0]      port;
    logic             wr_en;
    logic [31:0]      wr_addr;
    logic [9:0]       wr_len;
    trs_pkg::status_t status;
  } reply_t;

  // Mirrored registers and transfer state
  trs_pkg::cfg_t    regs;
  trs_pkg::status_t xfer_phase;
  logic [15:0]      block_count;
  logic [31:0]      bytes_rx;
  logic [15:0]      srv_port;
  logic             port_locked;
  logic [7:0]       retries;
  logic [15:0]      ticks;
  trs_pkg::kind_t   last_kind;
  logic [15:0]      last_value;

  reply_t expected_replies[$];

  // Fill in a packet and remember it for a later resend
  function automatic void send_packet(inout reply_t r, input trs_pkg::kind_t k,
                                      input logic [15:0] v);
    r.kind       = k;
    r.ack_block  = (k == trs_pkg::KIND_ACK) ? v : 16'd0;
    r.fault_code = (k == trs_pkg::KIND_ERR) ? v[2:0] : 3'd0;
    r.port       = (k == trs_pkg::KIND_NONE) ? 16'd0 :
                   (port_locked ? srv_port : trs_pkg::TFTP_PORT);
    last_kind    = k;
    last_value   = v;
  endfunction

  function automatic void burn_retry();
    retries = retries + 8'd1;
    if (retries >= regs.retry_limit)
      xfer_phase = trs_pkg::ST_FAIL;
  endfunction

  // Advance the transfer by one item and return the reply it causes
  function automatic reply_t predict_reply(trs_pkg::op_t op, logic [31:0] saddr,
                                           logic [15:0] sport, logic [7:0] opc,
                                           logic [15:0] blk, logic [9:0] dlen);
    reply_t r;
    logic [9:0] wlen;
    r = '0;
    case (op)
      trs_pkg::OP_START: begin
        xfer_phase  = trs_pkg::ST_RUN;
        block_count = 16'd0;
        bytes_rx    = 32'd0;
        srv_port    = 16'd0;
        port_locked = 1'b0;
        retries     = 8'd0;
        ticks       = 16'd0;
        send_packet(r, trs_pkg::KIND_RRQ, 16'd0);
      end
      trs_pkg::OP_TICK: begin
        if (xfer_phase == trs_pkg::ST_RUN) begin
          if (ticks >= regs.timeout_ticks) begin
            ticks = 16'd0;
            send_packet(r, last_kind, last_value);
            burn_retry();
          end else begin
            ticks = ticks + 16'd1;
          end
        end
      end
      trs_pkg::OP_DGRAM: begin
        if (xfer_phase == trs_pkg::ST_RUN) begin
          ticks = 16'd0;
          if (saddr == regs.server_address) begin
            if (!port_locked) begin
              srv_port    = sport;
              port_locked = 1'b1;
            end
            if (sport != srv_port) begin
              send_packet(r, trs_pkg::KIND_ERR, {13'd0, trs_pkg::ERR_TID});
            end else if (opc != trs_pkg::OPC_DATA) begin
              if (opc > trs_pkg::OPC_MAXLEGAL)
                send_packet(r, trs_pkg::KIND_ERR, {13'd0, trs_pkg::ERR_ILLEGAL});
              burn_retry();
            end else begin
              // next block in sequence; a count of 65535 takes nothing more
              if ({1'b0, block_count} + 17'd1 == {1'b0, blk}) begin
                wlen      = (dlen >= trs_pkg::HDR_LEN) ? dlen - trs_pkg::HDR_LEN : 10'd0;
                r.wr_en   = 1'b1;
                r.wr_addr = regs.flash_base + bytes_rx;
                r.wr_len  = wlen;
                bytes_rx  = bytes_rx + 32'(wlen);
                block_count = blk;
              end
              send_packet(r, trs_pkg::KIND_ACK, block_count);
              retries = 8'd0;
              if (dlen != trs_pkg::FULL_DGRAM_LEN)
                xfer_phase = trs_pkg::ST_DONE;
            end
          end
        end
      end
      default: ;
    endcase
    r.status = xfer_phase;
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Watch configuration, input and result channels
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      regs.server_address = 32'd0;
      regs.flash_base     = 32'd0;
      regs.retry_limit    = trs_pkg::RETRY_LIMIT_RST;
      regs.timeout_ticks  = trs_pkg::TIMEOUT_TICKS_RST;
      xfer_phase  = trs_pkg::ST_IDLE;
      block_count = 16'd0;
      bytes_rx    = 32'd0;
      srv_port    = 16'd0;
      port_locked = 1'b0;
      retries     = 8'd0;
      ticks       = 16'd0;
      last_kind   = trs_pkg::KIND_NONE;
      last_value  = 16'd0;
      mismatches  = 0;
      expected_replies.delete();
    end else begin
      if (cfg_we) begin
        case (trs_pkg::cfg_idx_t'(cfg_index))
          trs_pkg::CFG_SERVER_ADDR:   regs.server_address = cfg_data;
          trs_pkg::CFG_FLASH_BASE:    regs.flash_base     = cfg_data;
          trs_pkg::CFG_RETRY_LIMIT:   regs.retry_limit    = cfg_data[7:0];
          trs_pkg::CFG_TIMEOUT_TICKS: regs.timeout_ticks  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_replies.push_back(predict_reply(trs_pkg::op_t'(in_op), in_src_address,
                                                 in_src_port, in_pkt_opcode,
                                                 in_block_number, in_dgram_length));
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result accepted with no item outstanding");
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          mismatches += field_diff("send_kind", 32'(want.kind), 32'(out_send_kind))
                      + field_diff("send_block", 32'(want.ack_block), 32'(out_send_block))
                      + field_diff("error_code", 32'(want.fault_code), 32'(out_error_code))
                      + field_diff("dest_port", 32'(want.port), 32'(out_dest_port))
                      + field_diff("write_enable", 32'(want.wr_en), 32'(out_write_enable))
                      + field_diff("write_address", want.wr_addr, out_write_address)
                      + field_diff("write_length", 32'(want.wr_len), 32'(out_write_length))
                      + field_diff("status", 32'(want.status), 32'(out_status));
        end
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule

### bench/tb_tftp_receive_sequencer_core.sv
// Testbench top for tftp_receive_sequencer_core: drives configuration and items, stalls the
// result side, and reports the verdict. Depends on trs_pkg and tftp_reply_checker.
module tb_tftp_receive_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 350;

  typedef struct packed {
    trs_pkg::op_t op;
    logic [31:0]  addr;
    logic [15:0]  port;
    logic [7:0]   opc;
    logic [15:0]  blk;
    logic [9:0]   len;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [31:0] in_src_address = '0;
  logic [15:0] in_src_port = '0;
  logic [7:0]  in_pkt_opcode = '0;
  logic [15:0] in_block_number = '0;
  logic [9:0]  in_dgram_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_send_kind;
  logic [15:0] out_send_block;
  logic [2:0]  out_error_code;
  logic [15:0] out_dest_port;
  logic        out_write_enable;
  logic [31:0] out_write_address;
  logic [9:0]  out_write_length;
  logic [1:0]  out_status;

  int mismatches;
  int outstanding;
  int cycle_count = 0;

  // Idle limits per side and the one-shot long stall request
  int in_gap_max = 13;
  int out_gap_max = 13;
  bit hold_request = 1'b0;

  // Transfer being steered by the stimulus
  logic [31:0] srv_addr;
  logic [15:0] xfer_port;
  logic [15:0] next_blk;
  bit          need_start;
  bit          fresh;

  tftp_receive_sequencer_core dut (.*);

  tftp_reply_checker u_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_tftp_receive_sequencer_core failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold when asked
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic rx_item_t pack_item(trs_pkg::op_t op, logic [31:0] a, logic [15:0] p,
                                         logic [7:0] o, logic [15:0] b, logic [9:0] l);
    rx_item_t it;
    it.op = op;
    it.addr = a;
    it.port = p;
    it.opc = o;
    it.blk = b;
    it.len = l;
    return it;
  endfunction

  function automatic rx_item_t data_item(logic [15:0] b, logic [9:0] l);
    return pack_item(trs_pkg::OP_DGRAM, srv_addr, xfer_port, trs_pkg::OPC_DATA, b, l);
  endfunction

  // Unused fields of starts, ticks and unused ops carry random bits
  function automatic rx_item_t bare_item(trs_pkg::op_t op);
    return pack_item(op, $urandom, 16'($urandom), 8'($urandom), 16'($urandom),
                     10'($urandom));
  endfunction

  task automatic offer(input rx_item_t it);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= it.op;
    in_src_address  <= it.addr;
    in_src_port     <= it.port;
    in_pkt_opcode   <= it.opc;
    in_block_number <= it.blk;
    in_dgram_length <= it.len;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_settings(logic [31:0] addr, logic [31:0] base, logic [7:0] limit,
                               logic [15:0] tmo);
    srv_addr = addr;
    cfg_we <= 1'b1;
    cfg_index <= trs_pkg::CFG_SERVER_ADDR;
    cfg_data <= addr;
    @(posedge clk);
    cfg_index <= trs_pkg::CFG_FLASH_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= trs_pkg::CFG_RETRY_LIMIT;
    cfg_data <= {24'd0, limit};
    @(posedge clk);
    cfg_index <= trs_pkg::CFG_TIMEOUT_TICKS;
    cfg_data <= {16'd0, tmo};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain every outstanding result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hand-picked sequence: idle inputs, latch, wraps, errors, resends, failure and endings
  task automatic directed_run();
    load_settings(32'hC0A8_0001, 32'hFFFF_FE00, 8'd3, 16'd2);
    xfer_port = 16'hFFFF;
    offer(bare_item(trs_pkg::OP_TICK));
    offer(data_item(16'd1, trs_pkg::FULL_DGRAM_LEN));
    offer(bare_item(trs_pkg::OP_UNUSED));
    offer(bare_item(trs_pkg::OP_START));
    offer(pack_item(trs_pkg::OP_DGRAM, ~srv_addr, xfer_port, trs_pkg::OPC_DATA, 16'd1,
                    trs_pkg::FULL_DGRAM_LEN));
    offer(data_item(16'd1, trs_pkg::FULL_DGRAM_LEN));
    offer(pack_item(trs_pkg::OP_DGRAM, srv_addr, 16'd0, trs_pkg::OPC_DATA, 16'd2,
                    trs_pkg::FULL_DGRAM_LEN));
    offer(data_item(16'd1, trs_pkg::FULL_DGRAM_LEN));
    offer(data_item(16'd3, trs_pkg::FULL_DGRAM_LEN));
    offer(data_item(16'd2, trs_pkg::FULL_DGRAM_LEN));
    offer(pack_item(trs_pkg::OP_DGRAM, srv_addr, xfer_port, trs_pkg::OPC_MAXLEGAL, 16'd0,
                    10'd4));
    offer(pack_item(trs_pkg::OP_DGRAM, srv_addr, xfer_port, 8'hFF, 16'hFFFF, 10'd527));
    repeat (3) offer(bare_item(trs_pkg::OP_TICK));
    offer(data_item(16'd3, trs_pkg::FULL_DGRAM_LEN));
    offer(bare_item(trs_pkg::OP_START));
    repeat (3) offer(bare_item(trs_pkg::OP_TICK));
    xfer_port = 16'd0;
    offer(pack_item(trs_pkg::OP_DGRAM, srv_addr, xfer_port, 8'd0, 16'd1,
                    trs_pkg::FULL_DGRAM_LEN));
    offer(data_item(16'd1, 10'd0));
    offer(bare_item(trs_pkg::OP_TICK));
    offer(bare_item(trs_pkg::OP_START));
    xfer_port = 16'h1234;
    offer(data_item(16'd1, 10'd527));
    settle();
  endtask

  // Mostly well-formed transfers with random content, mixed with faults and noise
  task automatic random_traffic(int count);
    int sent;
    int r;
    int k;
    logic [15:0] b;
    sent = 0;
    need_start = 1'b1;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (need_start || r < 3) begin
        xfer_port  = 16'($urandom);
        next_blk   = 16'd1;
        fresh      = 1'b1;
        need_start = 1'b0;
        offer(bare_item(trs_pkg::OP_START));
        sent++;
      end else if (fresh || r < 55) begin
        fresh = 1'b0;
        offer(data_item(next_blk, trs_pkg::FULL_DGRAM_LEN));
        next_blk++;
        sent++;
      end else if (r < 60) begin
        // closing block: any length but a full one
        k = $urandom_range(0, 526);
        if (k >= int'(trs_pkg::FULL_DGRAM_LEN)) k++;
        offer(data_item(next_blk, 10'(k)));
        need_start = 1'b1;
        sent++;
      end else if (r < 65) begin
        b = $urandom_range(0, 1) ? next_blk - 16'd1 : 16'($urandom);
        offer(data_item(b, ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 527))
                                                         : trs_pkg::FULL_DGRAM_LEN));
        sent++;
      end else if (r < 70) begin
        offer(pack_item(trs_pkg::OP_DGRAM, srv_addr,
                        xfer_port ^ 16'($urandom_range(1, 65535)),
                        $urandom_range(0, 1) ? trs_pkg::OPC_DATA : 8'($urandom),
                        16'($urandom), 10'($urandom_range(0, 527))));
        sent++;
      end else if (r < 74) begin
        offer(pack_item(trs_pkg::OP_DGRAM, srv_addr ^ ($urandom | 32'd1), xfer_port,
                        trs_pkg::OPC_DATA, next_blk, 10'($urandom_range(0, 527))));
        sent++;
      end else if (r < 79) begin
        k = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 254);
        if (k >= int'(trs_pkg::OPC_DATA)) k++;
        offer(pack_item(trs_pkg::OP_DGRAM, srv_addr, xfer_port, 8'(k), 16'($urandom),
                        10'($urandom_range(0, 527))));
        sent++;
      end else if (r < 92) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          offer(bare_item(trs_pkg::OP_TICK));
          sent++;
        end
      end else if (r < 94) begin
        offer(bare_item(trs_pkg::OP_UNUSED));
        sent++;
      end else begin
        offer(pack_item(trs_pkg::op_t'($urandom_range(1, 3)),
                        $urandom_range(0, 1) ? srv_addr : $urandom,
                        16'($urandom), 8'($urandom), 16'($urandom),
                        10'($urandom_range(0, 527))));
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [31:0] addr, logic [31:0] base, logic [7:0] limit,
                           logic [15:0] tmo, int igap, int ogap, bit squeeze);
    load_settings(addr, base, limit, tmo);
    in_gap_max  = igap;
    out_gap_max = ogap;
    hold_request = squeeze;
    random_traffic(PHASE_ITEMS);
    settle();
  endtask

  // Stimulus and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    directed_run();
    run_phase(32'd0, 32'd0, 8'd1, 16'd0, 13, 13, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 0, 0, 1'b0);
    run_phase($urandom, $urandom, 8'd0, 16'd3, 13, 0, 1'b0);
    run_phase($urandom, $urandom, 8'($urandom_range(2, 6)), 16'($urandom_range(0, 4)),
              0, 13, 1'b1);
    run_phase($urandom, $urandom, 8'd4, 16'd1, 13, 13, 1'b0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_tftp_receive_sequencer_core passed");
    else
      $display("tb_tftp_receive_sequencer_core failed");
    $finish;
  end

endmodule
